FILE: src/bgc_pkg.sv
// Shared constants, types and the gray weighting for the bitmap to grayscale converter.
`default_nettype none

package bgc_pkg;

   // Default sizes handed to the top level
   localparam int DEF_MAX_WIDTH     = 4096;
   localparam int DEF_MAX_HEIGHT    = 4096;
   localparam int DEF_PALETTE_DEPTH = 256;

   // Field widths
   localparam int CHAN_W      = 8;
   localparam int INDEX_W     = 8;
   localparam int GRAY_W      = 8;
   localparam int ADDR_W      = 24;
   localparam int RGB_W       = 3 * CHAN_W;
   localparam int REQ_DATA_W  = INDEX_W + RGB_W;
   localparam int RSP_DATA_W  = GRAY_W + ADDR_W;
   localparam int CSR_DATA_W  = 13;
   localparam int CSR_INDEX_W = 2;

   // Luma weights, sum of weights is 128
   localparam int W_RED   = 38;
   localparam int W_GREEN = 75;
   localparam int W_BLUE  = 15;
   localparam int W_SHIFT = 7;
   localparam int SUM_W   = CHAN_W + W_SHIFT;

   // Register indexes of the configuration port
   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_COLOR_MODE   = 2'd0,
      CSR_IMAGE_WIDTH  = 2'd1,
      CSR_IMAGE_HEIGHT = 2'd2,
      CSR_TOP_DOWN     = 2'd3
   } csr_index_type;

   // Request kinds carried on tuser
   typedef enum logic {
      OP_LOAD  = 1'b0,
      OP_PIXEL = 1'b1
   } op_type;

   // Color modes
   typedef enum logic {
      MODE_PALETTE = 1'b0,
      MODE_DIRECT  = 1'b1
   } color_mode_type;

   // Weighted gray value; the weighted sum never exceeds 128 * 255
   function automatic logic [GRAY_W-1:0] weigh(input logic [RGB_W-1:0] rgb);
      logic [SUM_W-1:0] sum;
      sum = SUM_W'(W_RED)   * SUM_W'(rgb[2*CHAN_W +: CHAN_W])
          + SUM_W'(W_GREEN) * SUM_W'(rgb[CHAN_W +: CHAN_W])
          + SUM_W'(W_BLUE)  * SUM_W'(rgb[0 +: CHAN_W]);
      return sum[W_SHIFT +: GRAY_W];
   endfunction

endpackage

`default_nettype wire

FILE: src/bgc_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module bgc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, holds its data while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

FILE: src/bitmap_to_grayscale_converter.sv
// Top level of the bitmap to grayscale converter: counters, palette and gray pipeline.
`default_nettype none

// Converts bitmap pixels, in file row order, to 8-bit gray = (38R + 75G + 15B) >> 7 with a
// top-down row-major destination address. A request with tuser = 1 is a pixel, with
// tuser = 0 a palette load that gives no response. The block takes one request per cycle;
// a pixel's response reaches rsp_tvalid through stage one and then the output register:
// the edge that accepts its request loads the palette RAM's registered read and stage one;
// when the output register is free, the gray weighting and row * width address multiply
// are loaded into it. Back-pressure on rsp_tready stalls req_tready only when both stages
// hold a pixel. Palette entries read before being loaded give undefined gray. The user
// writes configuration only while no pixel is in flight; the block does not enforce it.
module bitmap_to_grayscale_converter #(
   parameter int MAX_WIDTH     = bgc_pkg::DEF_MAX_WIDTH,
   parameter int MAX_HEIGHT    = bgc_pkg::DEF_MAX_HEIGHT,
   parameter int PALETTE_DEPTH = bgc_pkg::DEF_PALETTE_DEPTH
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   // request: [7:0] index, [15:8] red, [23:16] green, [31:24] blue
   input  wire logic [bgc_pkg::REQ_DATA_W-1:0]   req_tdata,
   // request kind: [0] op
   input  wire logic                             req_tuser,
   input  wire logic                             req_tvalid,
   output logic                                  req_tready,
   // response: [7:0] gray, [31:8] dest_address
   output logic      [bgc_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   output logic                                  rsp_tlast,
   output logic                                  rsp_tvalid,
   input  wire logic                             rsp_tready,
   input  wire logic                             csr_we,
   input  wire logic [bgc_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [bgc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import bgc_pkg::*;

   localparam int CW  = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
   localparam int RH  = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
   localparam int DW  = $clog2(MAX_WIDTH + 1);
   localparam int DH  = $clog2(MAX_HEIGHT + 1);
   localparam int PAW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
   localparam int MW  = ADDR_W;

   // Configuration registers
   logic                  color_mode_ff;
   logic [CSR_DATA_W-1:0] width_ff;
   logic [CSR_DATA_W-1:0] height_ff;
   logic                  top_down_ff;

   // Position counters
   logic [CW-1:0] col_ff, col_in;
   logic [RH-1:0] row_ff, row_in;

   // Stage one: palette read in flight, position resolved
   logic          s1_valid_ff, s1_valid_in;
   logic          s1_palette_ff;
   logic          s1_hit_ff;
   logic [RGB_W-1:0] s1_rgb_ff;
   logic [RH-1:0] s1_row_ff;
   logic [CW-1:0] s1_col_ff;
   logic          s1_last_ff;

   // Output register
   logic              rsp_valid_ff, rsp_valid_in;
   logic [GRAY_W-1:0] rsp_gray_ff;
   logic [ADDR_W-1:0] rsp_addr_ff;
   logic              rsp_last_ff;

   logic [INDEX_W-1:0] req_index;
   logic [RGB_W-1:0]   req_rgb;
   logic               req_accept;
   logic               pix_accept;
   logic               load_accept;
   logic               index_hit;
   logic               s1_take;
   logic [DW-1:0]      w_eff, w_m1;
   logic [DH-1:0]      h_eff, h_m1;
   logic [CW-1:0]      col_cur;
   logic [RH-1:0]      row_cur;
   logic               col_last, row_last;
   logic [RH-1:0]      dest_row;
   logic [RGB_W-1:0]   pal_rgb;
   logic [RGB_W-1:0]   pix_rgb;
   logic [MW-1:0]      addr_full;

   // Request unpacking; the palette entry is stored as {R, G, B}
   assign req_index = req_tdata[0 +: INDEX_W];
   assign req_rgb   = {req_tdata[INDEX_W +: CHAN_W],
                       req_tdata[INDEX_W + CHAN_W +: CHAN_W],
                       req_tdata[INDEX_W + 2*CHAN_W +: CHAN_W]};

   // Handshake: stage one drains when the output register is free
   assign s1_take     = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready  = !s1_valid_ff || s1_take;
   assign req_accept  = req_tvalid && req_tready;
   assign pix_accept  = req_accept && (req_tuser == OP_PIXEL);
   assign load_accept = req_accept && (req_tuser == OP_LOAD);
   assign index_hit   = ({1'b0, req_index} < (INDEX_W + 1)'(PALETTE_DEPTH));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         color_mode_ff <= MODE_PALETTE;
         width_ff      <= CSR_DATA_W'(1);
         height_ff     <= CSR_DATA_W'(1);
         top_down_ff   <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_COLOR_MODE:   color_mode_ff <= csr_wdata[0];
            CSR_IMAGE_WIDTH:  width_ff      <= csr_wdata;
            CSR_IMAGE_HEIGHT: height_ff     <= csr_wdata;
            CSR_TOP_DOWN:     top_down_ff   <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Effective image size: zero acts as one, large values saturate
   always_comb begin
      if (width_ff == '0) begin
         w_eff = DW'(1);
      end else if (32'(width_ff) > MAX_WIDTH) begin
         w_eff = DW'(MAX_WIDTH);
      end else begin
         w_eff = DW'(width_ff);
      end
      if (height_ff == '0) begin
         h_eff = DH'(1);
      end else if (32'(height_ff) > MAX_HEIGHT) begin
         h_eff = DH'(MAX_HEIGHT);
      end else begin
         h_eff = DH'(height_ff);
      end
   end

   assign w_m1 = w_eff - DW'(1);
   assign h_m1 = h_eff - DH'(1);

   // Current position; a counter left out of range by a size change restarts at zero
   assign col_cur  = (DW'(col_ff) < w_eff) ? col_ff : '0;
   assign row_cur  = (DH'(row_ff) < h_eff) ? row_ff : '0;
   assign col_last = (col_cur == CW'(w_m1));
   assign row_last = (row_cur == RH'(h_m1));
   assign dest_row = top_down_ff ? row_cur : (RH'(h_m1) - row_cur);

   // Next position
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (pix_accept) begin
         if (col_last) begin
            col_in = '0;
            row_in = row_last ? '0 : (row_cur + RH'(1));
         end else begin
            col_in = col_cur + CW'(1);
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Palette: loads write, palette pixels read with the request
   bgc_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette (
      .clock   (clock),
      .wr_en   (load_accept && index_hit),
      .wr_addr (req_index[PAW-1:0]),
      .wr_data (req_rgb),
      .rd_en   (pix_accept),
      .rd_addr (req_index[PAW-1:0]),
      .rd_data (pal_rgb)
   );

   // Stage one registers
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (pix_accept) begin
         s1_valid_in = 1'b1;
      end else if (s1_take) begin
         s1_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pix_accept) begin
         s1_palette_ff <= (color_mode_ff == MODE_PALETTE);
         s1_hit_ff     <= index_hit;
         s1_rgb_ff     <= req_rgb;
         s1_row_ff     <= dest_row;
         s1_col_ff     <= col_cur;
         s1_last_ff    <= col_last && row_last;
      end
   end

   // Gray weighting and destination address
   always_comb begin
      if (s1_palette_ff) begin
         pix_rgb = s1_hit_ff ? pal_rgb : '0;
      end else begin
         pix_rgb = s1_rgb_ff;
      end
   end

   assign addr_full = MW'(s1_row_ff) * MW'(w_eff) + MW'(s1_col_ff);

   // Output register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (s1_take) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_take) begin
         rsp_gray_ff <= weigh(pix_rgb);
         rsp_addr_ff <= addr_full[ADDR_W-1:0];
         rsp_last_ff <= s1_last_ff;
      end
   end

   assign rsp_tdata  = {rsp_addr_ff, rsp_gray_ff};
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tvalid = rsp_valid_ff;

`ifndef NO_ASSERTIONS
   // Input stalls only when both pipeline stages are occupied
   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (s1_valid_ff && rsp_valid_ff))
      else $error("request stalled with a free pipeline stage");

   // Only a pixel request fills stage one; palette loads give no response
   a_s1_from_pixel: assert property (@(posedge clock) disable iff (reset)
      $rose(s1_valid_ff) |-> $past(pix_accept))
      else $error("stage one filled without a pixel request");

   // The column wraps to zero after the final column of a row
   a_col_wrap: assert property (@(posedge clock) disable iff (reset)
      (pix_accept && col_last) |=> (col_ff == '0))
      else $error("column counter did not wrap at end of row");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_bitmap_to_grayscale_converter.sv
// Self-checking testbench for the bitmap to grayscale converter: planned requests, model, checks.
`timescale 1ns / 1ps

module tb_bitmap_to_grayscale_converter;
   import bgc_pkg::*;

   localparam int MAX_W        = DEF_MAX_WIDTH;
   localparam int MAX_H        = DEF_MAX_HEIGHT;
   localparam int LUMA_R       = 38;
   localparam int LUMA_G       = 75;
   localparam int LUMA_B       = 15;
   localparam int LUMA_SHIFT   = 7;
   localparam int TARGET_ITEMS = 1400;
   localparam int QUIET_CYCLES = 6;    // pipeline is two deep, leave margin
   localparam int HOLD_CYCLES  = 300;
   localparam int REPORT_MAX   = 10;

   // Entries of the request plan: requests plus pacing and configuration steps
   typedef enum logic [2:0] {
      PLAN_REQUEST,
      PLAN_CSR,
      PLAN_DRAIN,
      PLAN_HOLD,
      PLAN_PACE
   } plan_kind_type;

   typedef struct {
      plan_kind_type kind;
      op_type        op;
      logic [7:0]    index;
      logic [7:0]    red;
      logic [7:0]    green;
      logic [7:0]    blue;
      csr_index_type csr_sel;
      logic [12:0]   value;
   } plan_step_type;

   typedef struct {
      logic [7:0]  gray;
      logic [23:0] dest;
      logic        last;
   } gray_pixel_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic [REQ_DATA_W-1:0]  req_tdata  = '0;
   logic                   req_tuser  = 1'b0;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [RSP_DATA_W-1:0]  rsp_tdata;
   logic                   rsp_tlast;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic                   csr_we     = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_wdata  = '0;

   bitmap_to_grayscale_converter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   plan_step_type  request_plan[$];
   gray_pixel_type gray_due[$];

   // Shadow of the converter state, updated as requests are accepted
   logic [23:0]    pal_shadow [256];
   color_mode_type cfg_mode   = MODE_PALETTE;
   logic [12:0]    cfg_width  = 13'd1;
   logic [12:0]    cfg_height = 13'd1;
   logic           cfg_top    = 1'b0;
   int             col_at     = 0;
   int             row_at     = 0;

   // Generation-side view of the palette and mode
   bit             gen_loaded [256];
   logic [7:0]     gen_loaded_list[$];
   color_mode_type gen_mode = MODE_PALETTE;
   int             planned  = 0;

   int mismatches = 0;
   int n_pixels   = 0;
   int n_loads    = 0;
   int n_images   = 0;
   int n_csr      = 0;
   int n_checked  = 0;

   int hold_asks = 0;

   // ------------------------------------------------------------------
   // Plan builders
   // ------------------------------------------------------------------
   task automatic plan_req(input op_type op, input logic [7:0] idx,
                           input logic [7:0] r, input logic [7:0] g, input logic [7:0] b);
      plan_step_type s;
      s = '{kind: PLAN_REQUEST, op: op, index: idx, red: r, green: g, blue: b,
            csr_sel: CSR_COLOR_MODE, value: '0};
      request_plan.push_back(s);
      planned++;
      if (op == OP_LOAD && !gen_loaded[idx]) begin
         gen_loaded[idx] = 1'b1;
         gen_loaded_list.push_back(idx);
      end
   endtask

   task automatic plan_mark(input plan_kind_type k, input csr_index_type sel,
                            input logic [12:0] v);
      plan_step_type s;
      s = '{kind: k, op: OP_LOAD, index: '0, red: '0, green: '0, blue: '0,
            csr_sel: sel, value: v};
      request_plan.push_back(s);
      if (k == PLAN_CSR && sel == CSR_COLOR_MODE)
         gen_mode = color_mode_type'(v[0]);
   endtask

   // 1-bit registers get random junk in the unused upper bits
   function automatic logic [12:0] flag_word(input logic bit0);
      logic [31:0] noise;
      noise = $urandom;
      return {noise[11:0], bit0};
   endfunction

   // Pixel with random content; palette mode only points at loaded entries
   task automatic plan_random_pixel();
      logic [31:0] rnd;
      logic [7:0]  idx;
      rnd = $urandom;
      idx = rnd[7:0];
      if (gen_mode == MODE_PALETTE)
         idx = gen_loaded_list[$urandom_range(0, gen_loaded_list.size() - 1)];
      plan_req(OP_PIXEL, idx, rnd[15:8], rnd[23:16], rnd[31:24]);
   endtask

   task automatic plan_random_load();
      logic [31:0] rnd;
      rnd = $urandom;
      plan_req(OP_LOAD, rnd[7:0], rnd[15:8], rnd[23:16], rnd[31:24]);
   endtask

   // ------------------------------------------------------------------
   // Model of the converter
   // ------------------------------------------------------------------
   function automatic int fit_dim(input logic [12:0] v, input int maxv);
      if (v == 0)
         return 1;
      if (int'(v) > maxv)
         return maxv;
      return int'(v);
   endfunction

   task automatic convert_request(input plan_step_type s);
      logic [23:0]    rgb;
      int             w;
      int             h;
      int             col;
      int             row;
      int             dest_row;
      int             sum;
      gray_pixel_type p;
      if (s.op == OP_LOAD) begin
         pal_shadow[s.index] = {s.red, s.green, s.blue};
         n_loads++;
      end else begin
         rgb = (cfg_mode == MODE_PALETTE) ? pal_shadow[s.index] : {s.red, s.green, s.blue};
         sum = LUMA_R * int'(rgb[23:16]) + LUMA_G * int'(rgb[15:8]) + LUMA_B * int'(rgb[7:0]);
         w   = fit_dim(cfg_width, MAX_W);
         h   = fit_dim(cfg_height, MAX_H);
         col = (col_at < w) ? col_at : 0;
         row = (row_at < h) ? row_at : 0;
         dest_row = cfg_top ? row : (h - 1 - row);
         p.gray = sum[LUMA_SHIFT +: 8];
         p.dest = 24'(dest_row * w + col);
         p.last = (col == w - 1) && (row == h - 1);
         gray_due.push_back(p);
         n_pixels++;
         if (p.last)
            n_images++;
         if (col == w - 1) begin
            col_at = 0;
            row_at = (row == h - 1) ? 0 : row + 1;
         end else begin
            col_at = col + 1;
            row_at = row;
         end
      end
   endtask

   // ------------------------------------------------------------------
   // Driver: request channel and configuration port
   // ------------------------------------------------------------------
   plan_step_type cur_req;
   int            quiet_cycles = 0;
   int            burst_left   = 1;
   int            gap_left     = 0;
   bit            steady       = 1'b0;

   always @(posedge clock) begin
      plan_step_type          step;
      logic                   v_n;
      logic                   u_n;
      logic [REQ_DATA_W-1:0]  d_n;
      logic                   we_n;
      logic [CSR_INDEX_W-1:0] ci_n;
      logic [CSR_DATA_W-1:0]  wd_n;
      v_n  = req_tvalid;
      u_n  = req_tuser;
      d_n  = req_tdata;
      we_n = 1'b0;
      ci_n = csr_index;
      wd_n = csr_wdata;
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            convert_request(cur_req);
            v_n = 1'b0;
         end
         // quiet = nothing offered and nothing outstanding
         if (req_tvalid || gray_due.size() != 0)
            quiet_cycles = 0;
         else
            quiet_cycles++;
         if (!v_n && request_plan.size() != 0) begin
            step = request_plan[0];
            case (step.kind)
               PLAN_REQUEST: begin
                  if (gap_left > 0) begin
                     gap_left--;
                  end else begin
                     void'(request_plan.pop_front());
                     cur_req = step;
                     v_n = 1'b1;
                     u_n = step.op;
                     d_n = {step.blue, step.green, step.red, step.index};
                     if (!steady) begin
                        burst_left--;
                        if (burst_left <= 0) begin
                           burst_left = $urandom_range(1, 40);
                           gap_left = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 12)
                                                                  : $urandom_range(0, 2);
                        end
                     end
                  end
               end
               PLAN_CSR: begin
                  if (quiet_cycles >= QUIET_CYCLES) begin
                     void'(request_plan.pop_front());
                     we_n = 1'b1;
                     ci_n = step.csr_sel;
                     wd_n = step.value;
                     n_csr++;
                     case (step.csr_sel)
                        CSR_COLOR_MODE:   cfg_mode   = color_mode_type'(step.value[0]);
                        CSR_IMAGE_WIDTH:  cfg_width  = step.value;
                        CSR_IMAGE_HEIGHT: cfg_height = step.value;
                        CSR_TOP_DOWN:     cfg_top    = step.value[0];
                        default: ;
                     endcase
                  end
               end
               PLAN_DRAIN: begin
                  if (quiet_cycles >= QUIET_CYCLES)
                     void'(request_plan.pop_front());
               end
               PLAN_HOLD: begin
                  void'(request_plan.pop_front());
                  hold_asks <= hold_asks + 1;
               end
               PLAN_PACE: begin
                  void'(request_plan.pop_front());
                  steady = step.value[0];
                  gap_left = 0;
               end
               default: void'(request_plan.pop_front());
            endcase
         end
      end
      req_tvalid <= v_n;
      req_tuser  <= u_n;
      req_tdata  <= d_n;
      csr_we     <= we_n;
      csr_index  <= ci_n;
      csr_wdata  <= wd_n;
   end

   // ------------------------------------------------------------------
   // Monitor: response check and receiver stall pattern
   // ------------------------------------------------------------------
   int  hold_taken   = 0;
   int  hold_left    = 0;
   int  pattern_left = 0;
   int  pattern_mode = 0;

   always @(posedge clock) begin
      gray_pixel_type want;
      gray_pixel_type got;
      logic           rdy_n;
      rdy_n = rsp_tready;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            got.gray = rsp_tdata[7:0];
            got.dest = rsp_tdata[31:8];
            got.last = rsp_tlast;
            if (gray_due.size() == 0) begin
               mismatches++;
               if (mismatches <= REPORT_MAX)
                  $display("%0t: response with no pixel due: gray %0d addr %0d last %0b",
                           $time, got.gray, got.dest, got.last);
            end else begin
               want = gray_due.pop_front();
               n_checked++;
               if (got.gray !== want.gray || got.dest !== want.dest ||
                   got.last !== want.last) begin
                  mismatches++;
                  if (mismatches <= REPORT_MAX)
                     $display("%0t: pixel %0d: want gray %0d addr %0d last %0b, got %0d %0d %0b",
                              $time, n_checked, want.gray, want.dest, want.last,
                              got.gray, got.dest, got.last);
               end
            end
         end
         // long hold-off on request, else a rotating stall pattern
         if (hold_asks != hold_taken) begin
            hold_taken = hold_asks;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rdy_n = 1'b0;
         end else begin
            if (pattern_left == 0) begin
               pattern_mode = $urandom_range(0, 3);
               pattern_left = $urandom_range(20, 120);
            end
            pattern_left--;
            case (pattern_mode)
               0:       rdy_n = 1'b1;
               1:       rdy_n = ($urandom_range(0, 3) != 0);
               2:       rdy_n = ($urandom_range(0, 3) == 0);
               default: rdy_n = ~rsp_tready;
            endcase
         end
      end
      rsp_tready <= rdy_n;
   end

   // ------------------------------------------------------------------
   // Stimulus plan and end of run
   // ------------------------------------------------------------------
   initial begin
      int seg;
      int k;
      int w;
      int h;
      int area;
      int npix;
      bit pal_mode;
      bit top;

      // palette-mode basics at reset size 1x1: black, white and the primaries
      plan_req(OP_LOAD, 8'd0,   8'd0,   8'd0,   8'd0);
      plan_req(OP_LOAD, 8'd255, 8'd255, 8'd255, 8'd255);
      plan_req(OP_LOAD, 8'd1,   8'd255, 8'd0,   8'd0);
      plan_req(OP_LOAD, 8'd2,   8'd0,   8'd255, 8'd0);
      plan_req(OP_LOAD, 8'd3,   8'd0,   8'd0,   8'd255);
      // color fields of a palette pixel are don't-care
      plan_req(OP_PIXEL, 8'd255, 8'd0,   8'd0,   8'd0);
      plan_req(OP_PIXEL, 8'd0,   8'd255, 8'd255, 8'd255);
      plan_req(OP_PIXEL, 8'd1,   8'hA5,  8'h5A,  8'h3C);
      plan_req(OP_PIXEL, 8'd2,   8'd0,   8'd0,   8'd0);
      plan_req(OP_PIXEL, 8'd3,   8'd255, 8'd255, 8'd255);

      // direct mode, 3x2 top-down; index is don't-care
      plan_mark(PLAN_CSR, CSR_COLOR_MODE,   flag_word(MODE_DIRECT));
      plan_mark(PLAN_CSR, CSR_IMAGE_WIDTH,  13'd3);
      plan_mark(PLAN_CSR, CSR_IMAGE_HEIGHT, 13'd2);
      plan_mark(PLAN_CSR, CSR_TOP_DOWN,     flag_word(1'b1));
      plan_req(OP_PIXEL, 8'hFF, 8'd255, 8'd255, 8'd255);
      plan_req(OP_PIXEL, 8'h00, 8'd0,   8'd0,   8'd0);
      plan_req(OP_PIXEL, 8'h5A, 8'd255, 8'd0,   8'd0);
      plan_req(OP_PIXEL, 8'hA5, 8'd0,   8'd255, 8'd0);
      plan_req(OP_PIXEL, 8'h0F, 8'd0,   8'd0,   8'd255);
      plan_req(OP_PIXEL, 8'hF0, 8'h55,  8'hAA,  8'h5A);

      // zero size acts as one
      plan_mark(PLAN_CSR, CSR_IMAGE_WIDTH,  13'd0);
      plan_mark(PLAN_CSR, CSR_IMAGE_HEIGHT, 13'd0);
      plan_mark(PLAN_CSR, CSR_TOP_DOWN,     flag_word(1'b0));
      plan_req(OP_PIXEL, 8'd7, 8'd12, 8'd200, 8'd99);

      // oversize saturates to the maximum, bottom-up gives the top addresses
      plan_mark(PLAN_CSR, CSR_IMAGE_WIDTH,  13'h1FFF);
      plan_mark(PLAN_CSR, CSR_IMAGE_HEIGHT, 13'h1FFF);
      plan_req(OP_PIXEL, 8'd0, 8'd1,   8'd2,   8'd3);
      plan_req(OP_PIXEL, 8'd0, 8'd254, 8'd253, 8'd252);

      // exact maximum, top-down, counters carry on
      plan_mark(PLAN_CSR, CSR_IMAGE_WIDTH,  13'(MAX_W));
      plan_mark(PLAN_CSR, CSR_IMAGE_HEIGHT, 13'(MAX_H));
      plan_mark(PLAN_CSR, CSR_TOP_DOWN,     flag_word(1'b1));
      plan_req(OP_PIXEL, 8'd0, 8'd128, 8'd128, 8'd128);

      // shrink below the running column count: counter restarts at zero
      plan_mark(PLAN_CSR, CSR_IMAGE_WIDTH,  13'd2);
      plan_mark(PLAN_CSR, CSR_IMAGE_HEIGHT, 13'd2);
      plan_req(OP_PIXEL, 8'd0, 8'd10, 8'd20, 8'd30);
      plan_req(OP_PIXEL, 8'd0, 8'd40, 8'd50, 8'd60);
      plan_mark(PLAN_DRAIN, CSR_COLOR_MODE, '0);

      // random segments: mostly whole small images, some broken or huge
      seg = 0;
      while (planned < TARGET_ITEMS) begin
         seg++;
         pal_mode = $urandom_range(0, 1);
         top      = $urandom_range(0, 1);
         k = $urandom_range(0, 99);
         if (k < 80) begin
            w = $urandom_range(1, 8);
            h = $urandom_range(1, 8);
         end else if (k < 90) begin
            w = $urandom_range(9, 40);
            h = $urandom_range(1, 2);
         end else if (k < 95) begin
            w = $urandom_range(0, 1);
            h = $urandom_range(0, 3);
         end else begin
            w = $urandom_range(4000, 8191);
            h = $urandom_range(4000, 8191);
         end
         plan_mark(PLAN_PACE, CSR_COLOR_MODE, 13'($urandom_range(0, 99) < 15));
         plan_mark(PLAN_CSR, CSR_COLOR_MODE,   flag_word(pal_mode ? MODE_PALETTE : MODE_DIRECT));
         plan_mark(PLAN_CSR, CSR_IMAGE_WIDTH,  13'(w));
         plan_mark(PLAN_CSR, CSR_IMAGE_HEIGHT, 13'(h));
         plan_mark(PLAN_CSR, CSR_TOP_DOWN,     flag_word(top));

         area = fit_dim(13'(w), MAX_W) * fit_dim(13'(h), MAX_H);
         if (area <= 80) begin
            npix = area * $urandom_range(1, 2);
            if ($urandom_range(0, 3) == 0)
               npix = $urandom_range(1, npix);
         end else begin
            npix = $urandom_range(3, 20);
         end

         if (seg == 3 || seg == 40) begin
            plan_mark(PLAN_HOLD, CSR_COLOR_MODE, '0);
            if (npix < 10)
               npix = 10;
         end

         if (pal_mode)
            repeat ($urandom_range(0, 3)) plan_random_load();
         for (int i = 0; i < npix; i++) begin
            if (seg % 25 == 0 && i == npix / 2)
               plan_mark(PLAN_DRAIN, CSR_COLOR_MODE, '0);
            if (pal_mode && $urandom_range(0, 9) == 0)
               plan_random_load();
            plan_random_pixel();
         end
      end

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      while (request_plan.size() != 0 || req_tvalid || gray_due.size() != 0)
         @(posedge clock);
      repeat (20) @(posedge clock);

      $display("covered %0d pixels (%0d whole images) and %0d palette loads",
               n_pixels, n_images, n_loads);
      $display("over %0d register writes, %0d responses checked, %0d mismatches",
               n_csr, n_checked, mismatches);
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // Watchdog
   initial begin
      #5_000_000;
      $display("timeout with %0d requests planned and %0d pixels due",
               request_plan.size(), gray_due.size());
      $display("end of test: mismatches");
      $finish;
   end

endmodule

FILE: files.f
src/bgc_pkg.sv
src/bgc_ram.sv
src/bitmap_to_grayscale_converter.sv
sim/tb_bitmap_to_grayscale_converter.sv
